>>> src/kpi_pkg.sv
// package: shared types, constants and codes for the keyframe pose interpolator
package kpi_pkg;

  localparam int KPI_MAX_KEYS    = 8;
  localparam int KPI_VAL_W       = 16;
  localparam int KPI_POSE_W      = 6 * KPI_VAL_W;
  localparam int KPI_IN_DATA_W   = 136;
  localparam int KPI_OUT_DATA_W  = 96;
  localparam logic [3:0] KPI_COUNT_RESET = 4'd6;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT,
    ST_MOD,
    ST_SCAN,
    ST_FAC,
    ST_PA,
    ST_PB,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } kpi_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] rem_init;
    logic [16:0] dividend;
    logic [4:0]  steps;
    logic [15:0] divisor;
  } kpi_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
    logic [15:0] quo;
  } kpi_div_rsp_t;

endpackage

>>> src/kpi_ram.sv
// generic single write port ram with registered read
module kpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/kpi_div.sv
// bit-serial restoring divider: one quotient bit per cycle
module kpi_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kpi_pkg::kpi_div_req_t req,
  output kpi_pkg::kpi_div_rsp_t rsp
);
  import kpi_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] dvd_r, dvd_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] div_r, div_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] cand;
  logic        ge;

  assign cand = {rem_r, dvd_r[16]};
  assign ge   = cand >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      dvd_nxt  = req.dividend;
      quo_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = req.steps;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(cand - {1'b0, div_r}) : cand[15:0];
      dvd_nxt = {dvd_r[15:0], 1'b0};
      quo_nxt = {quo_r[14:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

endmodule

>>> src/keyframe_pose_interpolator.sv
// top level: keyframe store, loop timer, segment search and pose interpolation
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  in_tdata (key and step fields), in_tuser (opcode)
// out_     out  out_tvalid/out_tready out_tdata (pose), out_tuser (found)
// cfg_     in   cfg_wr_en            cfg_wr_data (key count)
//
// a write word is stored in the key memories as it is accepted; an advance word passes through
// the serial divider (modulo, then factor), the one-read-a-cycle scan of the key time
// memory and the shared lane multiplier
// reset clears elapsed time and held pose and sets the key count to six; key memories
// stay unset
// a new word is taken once the previous one is finished, even while its result
// still waits in the output register
module keyframe_pose_interpolator #(
  parameter int MAX_KEYS = kpi_pkg::KPI_MAX_KEYS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // key_index, key_time, key_pos_x/y/z, key_rot_x/y/z, step_time, zero pad
  input  logic [kpi_pkg::KPI_IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z
  output logic [kpi_pkg::KPI_OUT_DATA_W-1:0] out_tdata,
  // found
  output logic                               out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [3:0]                         cfg_wr_data
);
  import kpi_pkg::*;

  localparam int KW = $clog2(MAX_KEYS);

  function automatic logic [KW-1:0] to_addr(input logic [3:0] v);
    logic [6:0] w;
    w = {3'b000, v};
    return w[KW-1:0];
  endfunction

  kpi_state_t state_r, state_nxt;

  logic [3:0]            count_r;
  logic [15:0]           elapsed_r, elapsed_nxt;
  logic [KPI_POSE_W-1:0] held_r, held_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KPI_POSE_W-1:0] out_data_r, out_data_nxt;
  logic                  out_found_r, out_found_nxt;

  logic [15:0]           step_r, step_nxt;
  logic [3:0]            n_r, n_nxt;
  logic [15:0]           t0_r, t0_nxt;
  logic [3:0]            scan_r, scan_nxt;
  logic [3:0]            seg_r, seg_nxt;
  logic [15:0]           fac_r, fac_nxt;
  logic [KPI_POSE_W-1:0] pa_r, pa_nxt;
  logic [KPI_POSE_W-1:0] pb_r, pb_nxt;
  logic [2:0]            lane_r, lane_nxt;
  logic signed [33:0]    prod_r, prod_nxt;

  logic                  in_acc;
  logic [3:0]            n_eff;
  logic                  key_we;
  logic [KW-1:0]         key_waddr;
  logic [KW-1:0]         time_raddr;
  logic [KW-1:0]         pose_raddr;
  logic [15:0]           time_rdata;
  logic [KPI_POSE_W-1:0] pose_rdata;
  logic [KPI_POSE_W-1:0] key_pose;
  logic [16:0]           sum;
  logic [4:0]            scan_next;
  logic [15:0]           lane_a, lane_b;
  logic signed [17:0]    lane_diff;
  logic signed [33:0]    lane_acc;
  logic [15:0]           lane_res;

  kpi_div_req_t div_req;
  kpi_div_rsp_t div_rsp;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign n_eff     = ({3'b000, count_r} > 7'(MAX_KEYS)) ? 4'(MAX_KEYS) : count_r;
  assign key_we    = in_acc && (in_tuser == OP_WRITE) && ({4'b0000, in_tdata[2:0]} < 7'(MAX_KEYS));
  assign key_waddr = to_addr({1'b0, in_tdata[2:0]});
  assign key_pose  = in_tdata[114:19];
  assign sum       = {1'b0, elapsed_r} + {1'b0, step_r};
  assign scan_next = {1'b0, scan_r} + 5'd1;

  assign lane_a    = pa_r[lane_r*16 +: 16] ^ 16'h8000;
  assign lane_b    = pb_r[lane_r*16 +: 16] ^ 16'h8000;
  assign lane_diff = $signed({2'b00, lane_b}) - $signed({2'b00, lane_a});
  assign lane_acc  = $signed({2'b00, lane_a, 16'h8000}) + prod_r;
  assign lane_res  = lane_acc[31:16] ^ 16'h8000;

  kpi_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_tdata[18:3]),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  kpi_ram #(.WIDTH(KPI_POSE_W), .DEPTH(MAX_KEYS)) u_pose_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_pose),
    .raddr (pose_raddr),
    .rdata (pose_rdata)
  );

  kpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    unique case (state_r)
      ST_MOD:  time_raddr = '0;
      ST_SCAN: time_raddr = to_addr(scan_next[3:0]);
      default: time_raddr = to_addr(n_eff - 4'd1);
    endcase
  end

  assign pose_raddr = (state_r == ST_PA) ? to_addr(seg_r + 4'd1) : to_addr(seg_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_ADVANCE) begin
          state_nxt = (n_eff == 4'd0) ? ST_DONE : ST_TOT;
        end
      end
      ST_TOT:  state_nxt = (time_rdata == 16'd0) ? ST_DONE : ST_MOD;
      ST_MOD: begin
        if (div_rsp.done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_r != 4'd0 && t0_r <= elapsed_r && elapsed_r < time_rdata) begin
          state_nxt = ST_FAC;
        end else if (scan_next >= {1'b0, n_r}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FAC: begin
        if (div_rsp.done) begin
          state_nxt = ST_PA;
        end
      end
      ST_PA:   state_nxt = ST_PB;
      ST_PB:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (lane_r == 3'd5) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    elapsed_nxt   = elapsed_r;
    held_nxt      = held_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    step_nxt      = step_r;
    n_nxt         = n_r;
    t0_nxt        = t0_r;
    scan_nxt      = scan_r;
    seg_nxt       = seg_r;
    fac_nxt       = fac_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    lane_nxt      = lane_r;
    prod_nxt      = prod_r;
    div_req       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        step_nxt  = in_tdata[130:115];
        n_nxt     = n_eff;
        found_nxt = 1'b0;
      end
      ST_TOT: begin
        if (time_rdata != 16'd0) begin
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = sum;
          div_req.steps    = 5'd17;
          div_req.divisor  = time_rdata;
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          elapsed_nxt = div_rsp.rem;
          scan_nxt    = '0;
        end
      end
      ST_SCAN: begin
        if (scan_r != 4'd0 && t0_r <= elapsed_r && elapsed_r < time_rdata) begin
          seg_nxt          = scan_r - 4'd1;
          div_req.start    = 1'b1;
          div_req.rem_init = elapsed_r - t0_r;
          div_req.dividend = '0;
          div_req.steps    = 5'd16;
          div_req.divisor  = time_rdata - t0_r;
        end else begin
          t0_nxt   = time_rdata;
          scan_nxt = scan_next[3:0];
        end
      end
      ST_FAC: begin
        if (div_rsp.done) begin
          fac_nxt = div_rsp.quo;
        end
      end
      ST_PA: pa_nxt = pose_rdata;
      ST_PB: begin
        pb_nxt   = pose_rdata;
        lane_nxt = '0;
      end
      ST_MUL: prod_nxt = 34'(lane_diff * $signed({2'b00, fac_r}));
      ST_ACC: begin
        held_nxt[lane_r*16 +: 16] = lane_res;
        lane_nxt                  = lane_r + 3'd1;
        found_nxt                 = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = held_r;
          out_found_nxt = found_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= KPI_COUNT_RESET;
      elapsed_r   <= '0;
      held_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      held_r      <= held_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
    step_r      <= step_nxt;
    n_r         <= n_nxt;
    t0_r        <= t0_nxt;
    scan_r      <= scan_nxt;
    seg_r       <= seg_nxt;
    fac_r       <= fac_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    lane_r      <= lane_nxt;
    prod_r      <= prod_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule
